### rtl/assert_macros.svh
// Assertion macros used by the checker file of the record list.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property checked on every clock edge outside reset.
`define PRL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication checked on the clock edge that follows the antecedent.
`define PRL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/prl_pkg.sv
// Shared types and codes of the positional record list.
`default_nettype none

package prl_pkg;

	localparam int POS_W   = 6;
	localparam int NAME_W  = 8;
	localparam int ID_W    = 32;
	localparam int COUNT_W = 7;

	typedef enum logic [1:0] {
		OP_TAIL = 2'd0,
		OP_HEAD = 2'd1,
		OP_READ = 2'd2,
		OP_DEL  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef struct packed {
		op_t               opcode;
		logic [NAME_W-1:0] student_name;
		logic [ID_W-1:0]   student_id;
		logic [POS_W-1:0]  position;
	} in_t;

	typedef struct packed {
		logic [NAME_W-1:0]  read_name;
		logic [ID_W-1:0]    read_id;
		status_t            status;
		logic [COUNT_W-1:0] entry_count;
	} out_t;

	typedef struct packed {
		logic [NAME_W-1:0] name;
		logic [ID_W-1:0]   id;
	} rec_t;

	typedef enum logic [1:0] {
		SEL_HOLD  = 2'd0,
		SEL_NEW   = 2'd1,
		SEL_LEFT  = 2'd2,
		SEL_RIGHT = 2'd3
	} cell_sel_t;

	typedef struct packed {
		cell_sel_t sel;
		logic      hit;
	} cell_ctl_t;

endpackage

`default_nettype wire

### rtl/positional_record_list.sv
// Top level of the positional record list: control, record chain and result register.
`default_nettype none

// Ordered list of up to CAPACITY records (name byte, 32-bit id), slot 0 the head. A transaction
// is taken on any edge where start is high; busy never rises, so one transaction per clock is
// sustained. Each transaction gives one result in the next cycle, shown for that single cycle
// with done high. Insert at head moves every slot of the cell chain at once; delete moves the
// slots from the deleted one on. A read picks the addressed slot through an OR of all cells.
// Status: 0 ok, 1 full on insert, 2 position not present. No clearing pass needed after reset.
module positional_record_list #(
	parameter int CAPACITY = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  prl_pkg::in_t   cmd,
	output logic           done,
	output prl_pkg::out_t  result
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > prl_pkg::POS_W) ? CNT_W : prl_pkg::POS_W;

	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_nxt;
	logic               done_q;
	prl_pkg::out_t      result_q;
	prl_pkg::out_t      result_nxt;

	logic               accept;
	logic               full;
	logic               in_range;
	logic               is_ins;
	logic               ins_ok;
	logic               del_ok;
	logic [CMP_W-1:0]   pos_ext;
	prl_pkg::rec_t      new_rec;
	prl_pkg::rec_t      rd_any;

	prl_pkg::cell_ctl_t ctl  [CAPACITY];
	prl_pkg::rec_t      data [CAPACITY];
	prl_pkg::rec_t      rd   [CAPACITY];

	assign busy     = 1'b0;
	assign accept   = start & ~busy;
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign pos_ext  = CMP_W'(cmd.position);
	assign in_range = (pos_ext < CMP_W'(count_q));
	assign is_ins   = (cmd.opcode == prl_pkg::OP_TAIL) || (cmd.opcode == prl_pkg::OP_HEAD);
	assign ins_ok   = accept & is_ins & ~full;
	assign del_ok   = accept & (cmd.opcode == prl_pkg::OP_DEL) & in_range;
	assign new_rec  = '{name: cmd.student_name, id: cmd.student_id};

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		prl_pkg::rec_t left_rec;
		prl_pkg::rec_t right_rec;

		if (i == 0) begin : g_head
			assign left_rec = new_rec;
		end else begin : g_mid_l
			assign left_rec = data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_rec = data[i];
		end else begin : g_mid_r
			assign right_rec = data[i+1];
		end

		always_comb begin
			ctl[i].hit = (CMP_W'(i) == pos_ext);
			priority if (ins_ok && cmd.opcode == prl_pkg::OP_TAIL &&
					CNT_W'(i) == count_q) begin
				ctl[i].sel = prl_pkg::SEL_NEW;
			end else if (ins_ok && cmd.opcode == prl_pkg::OP_HEAD) begin
				ctl[i].sel = prl_pkg::SEL_LEFT;
			end else if (del_ok && CMP_W'(i) >= pos_ext) begin
				// close the gap: everything from the deleted slot onwards moves up
				ctl[i].sel = prl_pkg::SEL_RIGHT;
			end else begin
				ctl[i].sel = prl_pkg::SEL_HOLD;
			end
		end

		prl_cell u_cell (
			.clk     (clk),
			.ctl     (ctl[i]),
			.new_rec (new_rec),
			.left    (left_rec),
			.right   (right_rec),
			.data    (data[i]),
			.rd      (rd[i])
		);
	end

	always_comb begin
		rd_any = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			rd_any = rd_any | rd[k];
		end
	end

	always_comb begin
		count_nxt = count_q;
		if (ins_ok) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (del_ok) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	always_comb begin
		result_nxt             = '0;
		result_nxt.entry_count = prl_pkg::COUNT_W'(count_nxt);
		if (is_ins) begin
			result_nxt.status = full ? prl_pkg::ST_FULL : prl_pkg::ST_OK;
		end else if (!in_range) begin
			result_nxt.status = prl_pkg::ST_RANGE;
		end else begin
			result_nxt.status = prl_pkg::ST_OK;
			if (cmd.opcode == prl_pkg::OP_READ) begin
				result_nxt.read_name = rd_any.name;
				result_nxt.read_id   = rd_any.id;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_nxt;
			done_q  <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result_nxt;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

### rtl/prl_cell.sv
// One slot of the record chain: holds a record and takes it from a neighbour or the input.
`default_nettype none

module prl_cell (
	input  logic              clk,
	input  prl_pkg::cell_ctl_t ctl,
	input  prl_pkg::rec_t     new_rec,
	input  prl_pkg::rec_t     left,
	input  prl_pkg::rec_t     right,
	output prl_pkg::rec_t     data,
	output prl_pkg::rec_t     rd
);

	prl_pkg::rec_t data_q;

	always_ff @(posedge clk) begin
		unique case (ctl.sel)
			prl_pkg::SEL_HOLD:  data_q <= data_q;
			prl_pkg::SEL_NEW:   data_q <= new_rec;
			prl_pkg::SEL_LEFT:  data_q <= left;
			prl_pkg::SEL_RIGHT: data_q <= right;
			default:            data_q <= data_q;
		endcase
	end

	assign data = data_q;
	// Drive the shared read bus only when this slot is the one addressed.
	assign rd   = ctl.hit ? data_q : '0;

endmodule

`default_nettype wire

### rtl/prl_checker.sv
// Port-level checks of the positional record list, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module prl_checker #(
	parameter int CAPACITY = 64
) (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input prl_pkg::in_t  cmd,
	input logic          done,
	input prl_pkg::out_t result
);

	logic [prl_pkg::COUNT_W-1:0] cap_count;
	logic                        cmd_seen;

	assign cap_count = prl_pkg::COUNT_W'(CAPACITY);
	assign cmd_seen  = (cmd.opcode == prl_pkg::OP_READ) || 1'b1;

	`PRL_ASSERT_NEXT(a_result_follows, start && !busy && cmd_seen, done, "transaction gave no result")
	`PRL_ASSERT_NEXT(a_no_spurious, !(start && !busy), !done, "result without a transaction")
	`PRL_ASSERT(a_fail_no_data, done && result.status != prl_pkg::ST_OK |-> result.read_name == '0 && result.read_id == '0, "failed transaction returned record data")
	`PRL_ASSERT(a_count_step, done && $past(done) |-> result.entry_count == $past(result.entry_count) || result.entry_count == prl_pkg::COUNT_W'($past(result.entry_count) + 1'b1) || prl_pkg::COUNT_W'(result.entry_count + 1'b1) == $past(result.entry_count), "record count moved by more than one")
	`PRL_ASSERT(a_full_count, done && result.status == prl_pkg::ST_FULL |-> result.entry_count == cap_count, "full reported below capacity")

endmodule

bind positional_record_list prl_checker #(.CAPACITY(CAPACITY)) u_prl_checker (.*);

`default_nettype wire
